>>> sv/rsp_pkg.sv
// ----------------------------------------------------------------------------
// rsp_pkg
// Shared constants and GF(256) arithmetic for the Reed-Solomon parity encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rsp_pkg;

  // Default and upper limit for the number of parity bytes the block holds.
  localparam int MAX_PARITY_DEF = 30;
  localparam int PARITY_LIMIT   = 64;

  // Parity count after reset, before saturation to the built size.
  localparam int RESET_PARITY = 10;

  localparam int CFG_W = 5;

  // Field polynomial x^8+x^4+x^3+x^2+1 without the x^8 term.
  localparam logic [7:0] GF_POLY_LOW = 8'h1D;

  typedef logic [7:0] gf_byte_t;
  typedef logic [PARITY_LIMIT-1:0][7:0] gen_vec_t;

  // Control for one step of the remainder register.
  typedef struct packed {
    logic step;
    logic flush;
  } rsp_step_t;

  // Multiplication in GF(256) by shift and add.
  function automatic gf_byte_t gf_mul(input gf_byte_t a, input gf_byte_t b);
    gf_byte_t x;
    gf_byte_t acc;
    x   = a;
    acc = '0;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) begin
        acc = acc ^ x;
      end
      x = x[7] ? ({x[6:0], 1'b0} ^ GF_POLY_LOW) : {x[6:0], 1'b0};
    end
    return acc;
  endfunction

  // Generator polynomial for n parity bytes. Byte i holds the coefficient of
  // x^(n-1-i); the leading coefficient of one is implied. Only evaluated at
  // elaboration.
  function automatic gen_vec_t gf_generator(input int n);
    gf_byte_t c [0:PARITY_LIMIT];
    gf_byte_t root;
    gen_vec_t res;
    for (int k = 0; k <= PARITY_LIMIT; k++) begin
      c[k] = '0;
    end
    c[0] = 8'd1;
    root = 8'd1;
    res  = '0;
    for (int i = 0; i < n; i++) begin
      for (int k = i + 1; k > 0; k--) begin
        c[k] = c[k-1] ^ gf_mul(c[k], root);
      end
      c[0] = gf_mul(c[0], root);
      root = gf_mul(root, 8'd2);
    end
    for (int i = 0; i < n; i++) begin
      res[i] = c[n-1-i];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

>>> sv/reed_solomon_parity_encoder_top.sv
// ----------------------------------------------------------------------------
// reed_solomon_parity_encoder_top
// Systematic Reed-Solomon parity encoder over GF(256), generator roots
// alpha^0 .. alpha^(n-1), with a configurable parity count n.
//
//   Channel  Direction  Handshake           Payload
//   in       input      in_valid/in_stall   in_data_byte, in_end_of_block
//   out      output     out_valid/out_stall out_parity_byte, out_last_parity
//   cfg      input      cfg_wr_en           cfg_wr_data (parity count)
//
// One data byte is absorbed per cycle unless an end-of-block byte is
// stalled; the remainder updates at the accepting edge. An end-of-block
// byte loads n parity bytes into the output buffer, which sends one beat
// per cycle while out_stall is low. An end-of-block byte is stalled until
// the previous parity's final beat leaves; other bytes are never stalled.
// Reset empties remainder and output buffer; n becomes min(10, MAX_PARITY).
// ----------------------------------------------------------------------------
`default_nettype none

module reed_solomon_parity_encoder_top #(
  parameter int MAX_PARITY = rsp_pkg::MAX_PARITY_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [7:0]                in_data_byte,
  input  wire logic                      in_end_of_block,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic      [7:0]                out_parity_byte,
  output logic                           out_last_parity,
  input  wire logic                      cfg_wr_en,
  input  wire logic [rsp_pkg::CFG_W-1:0] cfg_wr_data
);
  import rsp_pkg::*;

  localparam int CW      = $clog2(MAX_PARITY + 1);
  localparam int RESET_N = (RESET_PARITY > MAX_PARITY) ? MAX_PARITY : RESET_PARITY;
  localparam gen_vec_t GEN_RESET = gf_generator(RESET_N);

  logic [CW-1:0]              n_r;
  logic [CW-1:0]              n_nxt;
  logic [MAX_PARITY-1:0][7:0] gen_r;
  logic [MAX_PARITY-1:0][7:0] gen_sel;
  logic [MAX_PARITY-1:0][7:0] gen_tab [MAX_PARITY];
  logic [MAX_PARITY-1:0][7:0] rem_upd;
  logic                       buf_free;
  logic                       in_acc;
  rsp_step_t                  ctl;

  for (genvar k = 0; k < MAX_PARITY; k++) begin : g_gen
    localparam gen_vec_t GEN_K = gf_generator(k + 1);
    assign gen_tab[k] = GEN_K[MAX_PARITY-1:0];
  end

  // The written count saturates into 1 .. MAX_PARITY.
  always_comb begin
    if (cfg_wr_data == '0) begin
      n_nxt = CW'(1);
    end else if (32'(cfg_wr_data) > 32'(MAX_PARITY)) begin
      n_nxt = CW'(MAX_PARITY);
    end else begin
      n_nxt = CW'(cfg_wr_data);
    end
  end

  always_comb begin
    gen_sel = gen_tab[0];
    for (int k = 1; k < MAX_PARITY; k++) begin
      if (n_nxt == CW'(k + 1)) begin
        gen_sel = gen_tab[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r   <= CW'(RESET_N);
      gen_r <= GEN_RESET[MAX_PARITY-1:0];
    end else if (cfg_wr_en) begin
      n_r   <= n_nxt;
      gen_r <= gen_sel;
    end
  end

  assign in_stall   = in_end_of_block && !buf_free;
  assign in_acc     = in_valid && !in_stall;
  assign ctl.step   = in_acc;
  assign ctl.flush  = in_end_of_block;

  rsp_lfsr #(
    .MAX_PARITY (MAX_PARITY),
    .CW         (CW)
  ) u_lfsr (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .data_byte (in_data_byte),
    .parity_n  (n_r),
    .gen       (gen_r),
    .rem_upd   (rem_upd)
  );

  rsp_obuf #(
    .MAX_PARITY (MAX_PARITY),
    .CW         (CW)
  ) u_obuf (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (in_acc && in_end_of_block),
    .load_data       (rem_upd),
    .load_n          (n_r),
    .buf_free        (buf_free),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_parity_byte (out_parity_byte),
    .out_last_parity (out_last_parity)
  );

endmodule

`default_nettype wire

>>> sv/rsp_lfsr.sv
// ----------------------------------------------------------------------------
// rsp_lfsr
// Remainder register of the encoder: absorbs one data byte per step.
// ----------------------------------------------------------------------------
`default_nettype none

module rsp_lfsr #(
  parameter int MAX_PARITY = rsp_pkg::MAX_PARITY_DEF,
  parameter int CW         = $clog2(MAX_PARITY + 1)
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire rsp_pkg::rsp_step_t            ctl,
  input  wire logic [7:0]                    data_byte,
  input  wire logic [CW-1:0]                 parity_n,
  input  wire logic [MAX_PARITY-1:0][7:0]    gen,
  output logic      [MAX_PARITY-1:0][7:0]    rem_upd
);
  import rsp_pkg::*;

  logic [MAX_PARITY-1:0][7:0] rem_r;
  logic [MAX_PARITY-1:0][7:0] rem_nxt;
  logic [7:0]                 fb;

  assign fb = data_byte ^ rem_r[0];

  // Entries at or above the active count keep their contents.
  for (genvar i = 0; i < MAX_PARITY; i++) begin : g_tap
    logic [7:0] prod;
    logic [7:0] upper;
    assign prod = gf_mul(fb, gen[i]);
    if (i + 1 < MAX_PARITY) begin : g_mid
      assign upper = rem_r[i+1];
    end else begin : g_top
      assign upper = '0;
    end
    always_comb begin
      if (CW'(i + 1) < parity_n) begin
        rem_upd[i] = upper ^ prod;
      end else if (CW'(i + 1) == parity_n) begin
        rem_upd[i] = prod;
      end else begin
        rem_upd[i] = rem_r[i];
      end
    end
  end

  always_comb begin
    rem_nxt = rem_r;
    if (ctl.step) begin
      rem_nxt = ctl.flush ? '0 : rem_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
    end else begin
      rem_r <= rem_nxt;
    end
  end

endmodule

`default_nettype wire

>>> sv/rsp_obuf.sv
// ----------------------------------------------------------------------------
// rsp_obuf
// Parity output buffer: loads a whole remainder and sends it byte by byte.
// ----------------------------------------------------------------------------
`default_nettype none

module rsp_obuf #(
  parameter int MAX_PARITY = rsp_pkg::MAX_PARITY_DEF,
  parameter int CW         = $clog2(MAX_PARITY + 1)
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          load,
  input  wire logic [MAX_PARITY-1:0][7:0]    load_data,
  input  wire logic [CW-1:0]                 load_n,
  output logic                               buf_free,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [7:0]                    out_parity_byte,
  output logic                               out_last_parity
);
  import rsp_pkg::*;

  logic [MAX_PARITY-1:0][7:0] par_r;
  logic [MAX_PARITY-1:0][7:0] par_nxt;
  logic [CW-1:0]              cnt_r;
  logic [CW-1:0]              cnt_nxt;
  logic                       pop;

  assign out_valid       = (cnt_r != '0);
  assign out_parity_byte = par_r[0];
  assign out_last_parity = (cnt_r == CW'(1));
  assign pop             = out_valid && !out_stall;

  // A new block may load when the buffer is empty or its final beat leaves now.
  assign buf_free = (cnt_r == '0) || (out_last_parity && !out_stall);

  always_comb begin
    par_nxt = par_r;
    cnt_nxt = cnt_r;
    if (load) begin
      par_nxt = load_data;
      cnt_nxt = load_n;
    end else if (pop) begin
      for (int i = 0; i + 1 < MAX_PARITY; i++) begin
        par_nxt[i] = par_r[i+1];
      end
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    par_r <= par_nxt;
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

>>> sv/rsp_checker.sv
// ----------------------------------------------------------------------------
// rsp_checker
// Port-level checks for the Reed-Solomon parity encoder, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module rsp_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       in_end_of_block,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] out_parity_byte,
  input wire logic       out_last_parity
);

  // A stalled result beat is held unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_parity_byte)
                               && $stable(out_last_parity))
    else $error("stalled parity beat changed");

  // Only end-of-block bytes can ever be held back.
  a_data_flows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_end_of_block |-> !in_stall)
    else $error("data byte stalled");

  // Closing a block always produces parity on the next cycle.
  a_parity_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_end_of_block |=> out_valid)
    else $error("no parity after end of block");

  // Once the final beat leaves and no new block closes, the output goes idle.
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_parity && !out_stall
      && !(in_valid && !in_stall && in_end_of_block) |=> !out_valid)
    else $error("parity beyond final beat");

endmodule

bind reed_solomon_parity_encoder_top rsp_checker u_rsp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .in_end_of_block (in_end_of_block),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_parity_byte (out_parity_byte),
  .out_last_parity (out_last_parity)
);

`default_nettype wire

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Reed-Solomon parity encoder. Data beats are
// driven through the valid/stall handshake and mirrored into a table-driven
// GF(256) LFSR model, whose parity beats are compared with the block's output
// in order. A directed table comes first, then random blocks across several
// parity counts, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rsp_pkg::*;

  localparam int PARITY_MAX      = MAX_PARITY_DEF;
  localparam logic [8:0] FIELD_POLY = 9'h11D;
  localparam int SETTLE_CYCLES   = 8;
  localparam int TAIL_CYCLES     = 40;
  localparam int HOLD_CYCLES     = 300;
  localparam int CYCLE_LIMIT     = 300000;
  localparam int PHASES          = 11;
  localparam int ITEMS_PER_PHASE = 41;
  localparam int HOLD_PHASE      = 5;
  localparam int QUIET_PHASE     = 8;
  localparam int REPORT_LINES    = 40;

  typedef enum logic [0:0] {
    ROW_BEAT,
    ROW_CFG
  } row_kind_e;

  // A typed row carries a parity value that every parity beat of its block
  // must equal; other rows are checked against the LFSR model.
  typedef struct packed {
    row_kind_e kind;
    logic [7:0] value;
    logic       eob;
    logic       typed;
    logic [7:0] typed_byte;
  } stim_row_t;

  typedef struct packed {
    gf_byte_t value;
    logic     last;
  } parity_beat_t;

  localparam int DIRECTED_ROWS = 28;
  localparam stim_row_t DIRECTED [0:DIRECTED_ROWS-1] = '{
    '{ROW_BEAT, 8'h00, 1'b1, 1'b1, 8'h00},  // reset count of ten, zero block
    '{ROW_BEAT, 8'hFF, 1'b1, 1'b0, 8'h00},
    '{ROW_BEAT, 8'h12, 1'b0, 1'b0, 8'h00},
    '{ROW_BEAT, 8'h34, 1'b0, 1'b0, 8'h00},
    '{ROW_BEAT, 8'h56, 1'b1, 1'b0, 8'h00},
    '{ROW_CFG,  8'd1,  1'b0, 1'b0, 8'h00},
    '{ROW_BEAT, 8'hA5, 1'b1, 1'b1, 8'hA5},  // one parity byte: g(x) = x + 1
    '{ROW_BEAT, 8'hFF, 1'b1, 1'b1, 8'hFF},
    '{ROW_BEAT, 8'h0F, 1'b0, 1'b0, 8'h00},
    '{ROW_BEAT, 8'hF0, 1'b1, 1'b1, 8'hFF},  // xor of the block
    '{ROW_CFG,  8'd30, 1'b0, 1'b0, 8'h00},
    '{ROW_BEAT, 8'hFF, 1'b1, 1'b0, 8'h00},
    '{ROW_BEAT, 8'h01, 1'b0, 1'b0, 8'h00},
    '{ROW_BEAT, 8'h80, 1'b1, 1'b0, 8'h00},
    '{ROW_CFG,  8'd0,  1'b0, 1'b0, 8'h00},  // saturates to one
    '{ROW_BEAT, 8'h3C, 1'b1, 1'b1, 8'h3C},
    '{ROW_CFG,  8'd31, 1'b0, 1'b0, 8'h00},  // saturates to the maximum
    '{ROW_BEAT, 8'h55, 1'b1, 1'b0, 8'h00},
    '{ROW_CFG,  8'd4,  1'b0, 1'b0, 8'h00},
    '{ROW_BEAT, 8'h11, 1'b0, 1'b0, 8'h00},
    '{ROW_CFG,  8'd8,  1'b0, 1'b0, 8'h00},  // grows in the middle of a block
    '{ROW_BEAT, 8'h22, 1'b0, 1'b0, 8'h00},
    '{ROW_CFG,  8'd3,  1'b0, 1'b0, 8'h00},  // shrinks in the middle of a block
    '{ROW_BEAT, 8'h33, 1'b0, 1'b0, 8'h00},
    '{ROW_CFG,  8'd8,  1'b0, 1'b0, 8'h00},  // grows back over stale entries
    '{ROW_BEAT, 8'h44, 1'b1, 1'b0, 8'h00},
    '{ROW_BEAT, 8'h00, 1'b0, 1'b0, 8'h00},
    '{ROW_BEAT, 8'h00, 1'b1, 1'b1, 8'h00}
  };

  logic             clk;
  logic             rst_n           = 1'b0;
  logic             in_valid        = 1'b0;
  logic             in_stall;
  logic [7:0]       in_data_byte    = 8'h00;
  logic             in_end_of_block = 1'b0;
  logic             out_valid;
  logic             out_stall       = 1'b0;
  logic [7:0]       out_parity_byte;
  logic             out_last_parity;
  logic             cfg_wr_en       = 1'b0;
  logic [CFG_W-1:0] cfg_wr_data     = '0;

  // Both sides stop idling while this is set.
  logic quiet = 1'b0;
  int   hold_requests = 0;
  int   hold_served   = 0;
  int   hold_left     = 0;

  // LFSR model state.
  int       gf_log [0:255];
  gf_byte_t gf_exp [0:509];
  gf_byte_t enc_gen [0:PARITY_MAX-1];
  gf_byte_t enc_rem [0:PARITY_MAX-1];
  int       enc_n;

  parity_beat_t parity_pending [$];

  int cycle_count    = 0;
  int mismatch_count = 0;
  int beats_sent     = 0;
  int blocks_done    = 0;
  int parity_checked = 0;
  int cfg_writes     = 0;

  reed_solomon_parity_encoder_top #(
    .MAX_PARITY(PARITY_MAX)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data_byte   (in_data_byte),
    .in_end_of_block(in_end_of_block),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_parity_byte(out_parity_byte),
    .out_last_parity(out_last_parity),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= REPORT_LINES) begin
      $display("MISMATCH at %0t: %s", $time, what);
    end
  endtask

  task automatic build_field_tables();
    logic [8:0] x;
    x = 9'd1;
    for (int i = 0; i < 255; i++) begin
      gf_exp[i]       = x[7:0];
      gf_exp[i + 255] = x[7:0];
      gf_log[x[7:0]]  = i;
      x = x << 1;
      if (x[8]) begin
        x = x ^ FIELD_POLY;
      end
    end
    gf_log[0] = 0;
  endtask

  function automatic gf_byte_t gf_times(input gf_byte_t a, input gf_byte_t b);
    if (a == 8'h00 || b == 8'h00) begin
      return 8'h00;
    end
    return gf_exp[gf_log[a] + gf_log[b]];
  endfunction

  // Appends one expected parity beat to the back of the queue.
  function automatic void expect_parity(input gf_byte_t value, input bit last);
    parity_beat_t beat;
    beat.value = value;
    beat.last  = last;
    parity_pending.insert(parity_pending.size(), beat);
  endfunction

  // Builds g(x) = (x + a^0)...(x + a^(n-1)) with descending coefficients, so
  // that enc_gen[i] is the coefficient of x^(n-1-i).
  task automatic load_generator(input logic [CFG_W-1:0] count);
    gf_byte_t poly [0:PARITY_MAX];
    int n;
    n = int'(count);
    if (n < 1) begin
      n = 1;
    end
    if (n > PARITY_MAX) begin
      n = PARITY_MAX;
    end
    enc_n = n;
    for (int k = 0; k <= PARITY_MAX; k++) begin
      poly[k] = 8'h00;
    end
    poly[0] = 8'h01;
    for (int i = 0; i < n; i++) begin
      for (int k = i + 1; k > 0; k--) begin
        poly[k] = poly[k] ^ gf_times(poly[k-1], gf_exp[i]);
      end
    end
    for (int j = 0; j < n; j++) begin
      enc_gen[j] = poly[j+1];
    end
  endtask

  // One LFSR step. Entries at or beyond the current count keep whatever they
  // held, and are only cleared at the end of a block.
  task automatic lfsr_absorb(input gf_byte_t data, input bit eob, input bit record);
    gf_byte_t fb;
    fb = data ^ enc_rem[0];
    for (int i = 0; i + 1 < enc_n; i++) begin
      enc_rem[i] = enc_rem[i+1] ^ gf_times(fb, enc_gen[i]);
    end
    enc_rem[enc_n-1] = gf_times(fb, enc_gen[enc_n-1]);
    if (eob) begin
      if (record) begin
        for (int i = 0; i < enc_n; i++) begin
          expect_parity(enc_rem[i], i == enc_n - 1);
        end
      end
      for (int i = 0; i < PARITY_MAX; i++) begin
        enc_rem[i] = 8'h00;
      end
      blocks_done++;
    end
  endtask

  // Offers one data beat and returns in the time step at which it is taken.
  task automatic send_data_beat(input gf_byte_t data, input bit eob);
    if (!quiet) begin
      while ($urandom_range(99) < 16) begin
        in_valid        <= 1'b0;
        in_data_byte    <= 8'($urandom);
        in_end_of_block <= 1'($urandom);
        @(posedge clk);
      end
    end
    in_valid        <= 1'b1;
    in_data_byte    <= data;
    in_end_of_block <= eob;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    beats_sent++;
  endtask

  // The count is only changed once all parity is out and the block has had
  // time to settle, even when a data block is still open.
  task automatic write_parity_count(input logic [CFG_W-1:0] count);
    in_valid <= 1'b0;
    while (parity_pending.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= count;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    load_generator(count);
    cfg_writes++;
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d parity beats outstanding",
               cycle_count, parity_pending.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    parity_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (parity_pending.size() == 0) begin
        report_mismatch($sformatf("unexpected parity beat %02h", out_parity_byte));
      end else begin
        want = parity_pending.pop_front();
        parity_checked++;
        if (out_parity_byte !== want.value) begin
          report_mismatch($sformatf("parity byte %02h, expected %02h",
                                    out_parity_byte, want.value));
        end
        if (out_last_parity !== want.last) begin
          report_mismatch($sformatf("last mark %b, expected %b",
                                    out_last_parity, want.last));
        end
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_requests != hold_served) begin
      hold_served = hold_requests;
      hold_left   = HOLD_CYCLES - 1;
      out_stall   <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < 16);
    end
  end

  initial begin
    stim_row_t        row;
    gf_byte_t         data;
    bit               eob;
    int               blk_left;
    logic [CFG_W-1:0] count;

    build_field_tables();
    load_generator(CFG_W'(RESET_PARITY));
    for (int i = 0; i < PARITY_MAX; i++) begin
      enc_rem[i] = 8'h00;
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      row = DIRECTED[r];
      if (row.kind == ROW_CFG) begin
        write_parity_count(row.value[CFG_W-1:0]);
      end else begin
        send_data_beat(row.value, row.eob);
        lfsr_absorb(row.value, row.eob, !row.typed);
        if (row.typed && row.eob) begin
          for (int i = 0; i < enc_n; i++) begin
            expect_parity(row.typed_byte, i == enc_n - 1);
          end
        end
      end
    end

    // Phases do not end on block boundaries, so many blocks see the parity
    // count change part way through.
    blk_left = 0;
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       count = CFG_W'(1);
        1:       count = CFG_W'(PARITY_MAX);
        2:       count = '0;
        3:       count = '1;
        default: count = CFG_W'($urandom_range(31));
      endcase
      write_parity_count(count);
      quiet <= (phase == QUIET_PHASE);
      if (phase == HOLD_PHASE) begin
        hold_requests <= hold_requests + 1;
      end
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (blk_left == 0) begin
          if (phase == HOLD_PHASE) begin
            blk_left = $urandom_range(2, 1);
          end else if ($urandom_range(99) < 85) begin
            blk_left = $urandom_range(6, 1);
          end else begin
            blk_left = $urandom_range(48, 7);
          end
        end
        blk_left--;
        data = 8'($urandom_range(255));
        eob  = (blk_left == 0);
        send_data_beat(data, eob);
        lfsr_absorb(data, eob, 1'b1);
      end
    end

    in_valid <= 1'b0;
    while (parity_pending.size() != 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    if (parity_pending.size() != 0) begin
      report_mismatch($sformatf("%0d parity beats never arrived", parity_pending.size()));
    end
    $display("Sent %0d data beats closing %0d blocks; %0d parity beats compared.",
             beats_sent, blocks_done, parity_checked);
    $display("Parity counts from 0 to 31 over %0d writes, with changes inside blocks.",
             cfg_writes);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/rsp_pkg.sv
sv/rsp_lfsr.sv
sv/rsp_obuf.sv
sv/reed_solomon_parity_encoder_top.sv
sv/rsp_checker.sv
sim/testbench.sv
